// ===== design/mvws_pkg.sv =====
// shared constants, types and helper function of the weight solver
`timescale 1ns / 1ps
package mvws_pkg;

    localparam int MAX_DIM = 8;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = ADDR_W + 1;

    localparam int WORD_W  = 32;
    localparam int PROD_W  = 40;
    localparam int ACC_W   = 48;
    localparam int SUM_W   = 40;
    localparam int NUM_W   = 64;
    localparam int DIVQ_W  = 57;
    localparam int DCNT_W  = $clog2(DIVQ_W + 1);
    localparam int LIMIT_W = 16;
    localparam int DIMR_W  = 4;

    localparam int ONE_Q16 = 65536;
    localparam int ONE_Q24 = 16777216;

    localparam logic CFG_DIMENSION = 1'b0;
    localparam logic CFG_NEAR_ZERO = 1'b1;

    localparam logic [DIMR_W-1:0]  DIM_RESET   = 4'd8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1;

    localparam logic signed [63:0] W_MAX = 64'sd2147483647;
    localparam logic signed [63:0] W_MIN = -64'sd2147483648;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [CNT_W-1:0]   n;
        logic [LIMIT_W-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mul_req;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [SUM_W-1:0] den;
    } t_div_req;

    function automatic t_word sat32(input logic signed [63:0] v);
        t_word r;
        if (v > W_MAX) begin
            r = W_MAX[WORD_W-1:0];
        end else if (v < W_MIN) begin
            r = W_MIN[WORD_W-1:0];
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/mvws_mul.sv =====
// two-stage signed multiplier with rounding shift back to q16.16
`timescale 1ns / 1ps
module mvws_mul
    import mvws_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mul_req                 i_req,
    output logic                     o_valid,
    output logic signed [PROD_W-1:0] o_result
);

    logic signed [63:0]       r_prod;
    logic                     r_v1;
    logic signed [PROD_W-1:0] r_res;
    logic                     r_v2;
    logic [63:0]              mag;
    logic [63:0]              rnd;
    logic signed [63:0]       res;

    always_comb begin
        mag = r_prod[63] ? (64'd0 - r_prod) : r_prod;
        rnd = (mag + 64'd8388608) >> 24;
        res = r_prod[63] ? $signed(64'd0 - rnd) : $signed(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
        end
        r_prod <= 64'(i_req.a) * 64'(i_req.b);
        r_res  <= res[PROD_W-1:0];
    end

    assign o_valid  = r_v2;
    assign o_result = r_res;

endmodule

// ===== design/mvws_div.sv =====
// bit-serial signed divider, rounded to nearest and saturated to 32 bits
`timescale 1ns / 1ps
module mvws_div
    import mvws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output logic     o_valid,
    output t_word    o_quot
);

    logic              r_busy;
    logic              r_valid;
    logic [DCNT_W-1:0] r_cnt;
    logic [DIVQ_W-1:0] r_dvd;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_md;
    logic              r_neg;
    t_word             r_quot;

    logic [NUM_W-1:0]  mn;
    logic [SUM_W-1:0]  md;
    logic [SUM_W:0]    trial;
    logic              ge;
    logic signed [63:0] qs;

    always_comb begin
        mn    = i_req.num[NUM_W-1] ? (NUM_W'(0) - i_req.num) : i_req.num;
        md    = i_req.den[SUM_W-1] ? (SUM_W'(0) - i_req.den) : i_req.den;
        trial = {r_rem, r_dvd[DIVQ_W-1]};
        ge    = trial >= {1'b0, r_md};
        qs    = $signed(64'(r_dvd));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
        if (i_req.start) begin
            r_dvd <= mn[DIVQ_W-1:0] + DIVQ_W'(md >> 1);
            r_md  <= md;
            r_rem <= '0;
            r_neg <= i_req.num[NUM_W-1] ^ i_req.den[SUM_W-1];
            r_cnt <= DCNT_W'(DIVQ_W);
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= ge ? SUM_W'(trial - {1'b0, r_md}) : trial[SUM_W-1:0];
            r_dvd <= {r_dvd[DIVQ_W-2:0], ge};
            r_cnt <= r_cnt - DCNT_W'(1);
        end else if (r_busy) begin
            r_quot <= sat32(r_neg ? (64'sd0 - qs) : qs);
        end
    end

    assign o_valid = r_valid;
    assign o_quot  = r_quot;

endmodule

// ===== design/mvws_seq.sv =====
// sequencer with matrix, factor and solution stores driving the shared units
`timescale 1ns / 1ps
module mvws_seq
    import mvws_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_word i_matrix_entry,
    input  logic  i_final_entry,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    output t_word o_weight,
    output logic  o_equal_fallback,
    output logic  o_pivot_error,
    output logic  o_last_weight
);

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_LOOP  = 7'b0000010,
        ST_AGET  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_MWAIT = 7'b0010000,
        ST_DWAIT = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    typedef enum logic [7:0] {
        PH_W = 8'b00000001,
        PH_D = 8'b00000010,
        PH_L = 8'b00000100,
        PH_Y = 8'b00001000,
        PH_Z = 8'b00010000,
        PH_X = 8'b00100000,
        PH_S = 8'b01000000,
        PH_E = 8'b10000000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [CNT_W-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic               r_first, n_first, r_err, n_err, r_flat, n_flat;
    logic [COUNT_W-1:0] r_count, n_count;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    t_word r_opb, n_opb, r_adata, r_ldata;
    t_word r_weight, n_weight;
    logic  r_equal, n_equal, r_perr, n_perr, r_last, n_last;

    t_word r_a_mem [DEPTH];
    t_word r_l_mem [DEPTH];
    t_word r_d [MAX_DIM];
    t_word r_w [MAX_DIM];
    t_word r_x [MAX_DIM];

    logic [COUNT_W-1:0] nn;
    logic [ADDR_W-1:0]  a_raddr, l_raddr, a_waddr, l_waddr;
    logic               a_we, l_we, d_we, w_we, x_we;
    t_word              l_wdata, d_wdata, w_wdata, x_wdata;
    logic [IDX_W-1:0]   d_idx, s_idx, d_widx, w_widx, x_widx;
    t_word              d_rd, s_rd, w_rd, acc_sat;
    logic [SUM_W-1:0]   mag;

    t_mul_req                 mul_req;
    logic                     mul_valid;
    logic signed [PROD_W-1:0] mul_res;
    t_div_req                 div_req;
    logic                     div_valid;
    t_word                    div_quot;

    function automatic logic [ADDR_W-1:0] l_at(input logic [CNT_W-1:0] r,
                                               input logic [CNT_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
    endfunction

    function automatic logic [ADDR_W-1:0] a_at(input logic [CNT_W-1:0] r,
                                               input logic [CNT_W-1:0] c,
                                               input logic [CNT_W-1:0] n);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(n) + ADDR_W'(c));
    endfunction

    mvws_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mul_req),
        .o_valid  (mul_valid),
        .o_result (mul_res)
    );

    mvws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_valid (div_valid),
        .o_quot  (div_quot)
    );

    always_comb begin
        nn      = COUNT_W'(i_cfg.n) * COUNT_W'(i_cfg.n);
        d_idx   = (r_phase == PH_W) ? r_k[IDX_W-1:0] :
                  (r_phase == PH_L) ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];
        s_idx   = ((r_phase == PH_Y) || (r_phase == PH_X && !r_first)) ?
                  r_k[IDX_W-1:0] : r_i[IDX_W-1:0];
        d_rd    = r_d[d_idx];
        s_rd    = r_x[s_idx];
        w_rd    = r_w[r_k[IDX_W-1:0]];
        acc_sat = sat32(64'(r_acc));
        mag     = r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_first  = r_first;
        n_err    = r_err;
        n_flat   = r_flat;
        n_count  = r_count;
        n_acc    = r_acc;
        n_sum    = r_sum;
        n_opb    = r_opb;
        n_weight = r_weight;
        n_equal  = r_equal;
        n_perr   = r_perr;
        n_last   = r_last;
        a_raddr  = '0;
        l_raddr  = '0;
        a_we     = 1'b0;
        a_waddr  = r_count[ADDR_W-1:0];
        l_we     = 1'b0;
        l_waddr  = l_at(r_i, r_j);
        l_wdata  = div_quot;
        d_we     = 1'b0;
        d_widx   = r_j[IDX_W-1:0];
        d_wdata  = acc_sat;
        w_we     = 1'b0;
        w_widx   = r_k[IDX_W-1:0];
        w_wdata  = sat32(64'(mul_res));
        x_we     = 1'b0;
        x_widx   = r_i[IDX_W-1:0];
        x_wdata  = acc_sat;
        mul_req  = '{start: 1'b0, a: r_ldata, b: r_opb};
        div_req  = '{start: 1'b0, num: '0, den: '0};

        case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    if (r_count < nn) begin
                        a_we    = 1'b1;
                        n_count = r_count + COUNT_W'(1);
                    end
                    if (i_final_entry) begin
                        n_count = '0;
                        n_state = ST_LOOP;
                        n_phase = PH_W;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_err   = 1'b0;
                        n_flat  = 1'b0;
                        n_first = 1'b1;
                    end
                end
            end
            ST_LOOP: begin
                case (r_phase)
                    PH_W: begin
                        if (r_k < r_j) begin
                            l_raddr = l_at(r_j, r_k);
                            n_opb   = d_rd;
                            n_state = ST_MUL;
                        end else begin
                            n_k     = '0;
                            n_first = 1'b1;
                            n_phase = PH_D;
                        end
                    end
                    PH_D: begin
                        if (r_first) begin
                            a_raddr = a_at(r_j, r_j, i_cfg.n);
                            n_state = ST_AGET;
                        end else if (r_k < r_j) begin
                            l_raddr = l_at(r_j, r_k);
                            n_opb   = w_rd;
                            n_state = ST_MUL;
                        end else begin
                            d_we = 1'b1;
                            if (acc_sat == '0) begin
                                n_err   = 1'b1;
                                n_phase = PH_E;
                                n_i     = '0;
                            end else begin
                                n_i     = r_j + CNT_W'(1);
                                n_k     = '0;
                                n_first = 1'b1;
                                n_phase = PH_L;
                            end
                        end
                    end
                    PH_L: begin
                        if (r_i == i_cfg.n) begin
                            n_k = '0;
                            if ((r_j + CNT_W'(1)) == i_cfg.n) begin
                                n_phase = PH_Y;
                                n_i     = '0;
                                n_first = 1'b1;
                            end else begin
                                n_j     = r_j + CNT_W'(1);
                                n_phase = PH_W;
                            end
                        end else if (r_first) begin
                            a_raddr = a_at(r_i, r_j, i_cfg.n);
                            n_state = ST_AGET;
                        end else if (r_k < r_j) begin
                            l_raddr = l_at(r_i, r_k);
                            n_opb   = w_rd;
                            n_state = ST_MUL;
                        end else begin
                            div_req = '{start: 1'b1, num: 64'(acc_sat) <<< 24,
                                        den: SUM_W'(d_rd)};
                            n_state = ST_DWAIT;
                        end
                    end
                    PH_Y: begin
                        if (r_i == i_cfg.n) begin
                            n_phase = PH_Z;
                            n_i     = '0;
                        end else if (r_first) begin
                            n_acc   = ACC_W'(ONE_Q16);
                            n_first = 1'b0;
                        end else if (r_k < r_i) begin
                            l_raddr = l_at(r_i, r_k);
                            n_opb   = s_rd;
                            n_state = ST_MUL;
                        end else begin
                            x_we    = 1'b1;
                            n_i     = r_i + CNT_W'(1);
                            n_k     = '0;
                            n_first = 1'b1;
                        end
                    end
                    PH_Z: begin
                        if (r_i == i_cfg.n) begin
                            n_phase = PH_X;
                            n_i     = i_cfg.n - CNT_W'(1);
                            n_first = 1'b1;
                        end else begin
                            div_req = '{start: 1'b1, num: 64'(s_rd) <<< 16,
                                        den: SUM_W'(d_rd)};
                            n_state = ST_DWAIT;
                        end
                    end
                    PH_X: begin
                        if (r_first) begin
                            n_acc   = ACC_W'(s_rd);
                            n_k     = r_i + CNT_W'(1);
                            n_first = 1'b0;
                        end else if (r_k < i_cfg.n) begin
                            l_raddr = l_at(r_k, r_i);
                            n_opb   = s_rd;
                            n_state = ST_MUL;
                        end else begin
                            x_we = 1'b1;
                            if (r_i == '0) begin
                                n_phase = PH_S;
                                n_sum   = '0;
                            end else begin
                                n_i     = r_i - CNT_W'(1);
                                n_first = 1'b1;
                            end
                        end
                    end
                    PH_S: begin
                        if (r_i == i_cfg.n) begin
                            n_flat  = {mag, 8'h00} < (SUM_W + 8)'(i_cfg.limit);
                            n_phase = PH_E;
                            n_i     = '0;
                        end else begin
                            n_sum = r_sum + SUM_W'(s_rd);
                            n_i   = r_i + CNT_W'(1);
                        end
                    end
                    PH_E: begin
                        if (r_i == i_cfg.n) begin
                            n_state = ST_LOAD;
                        end else if (r_err) begin
                            n_weight = '0;
                            n_equal  = 1'b0;
                            n_perr   = 1'b1;
                            n_last   = (r_i + CNT_W'(1)) == i_cfg.n;
                            n_state  = ST_OUT;
                        end else if (r_flat) begin
                            div_req = '{start: 1'b1, num: 64'(ONE_Q24),
                                        den: SUM_W'(i_cfg.n)};
                            n_state = ST_DWAIT;
                        end else begin
                            div_req = '{start: 1'b1, num: 64'(s_rd) <<< 24, den: r_sum};
                            n_state = ST_DWAIT;
                        end
                    end
                    default: begin
                        n_state = ST_LOAD;
                    end
                endcase
            end
            ST_AGET: begin
                n_acc   = ACC_W'(r_adata);
                n_first = 1'b0;
                n_state = ST_LOOP;
            end
            ST_MUL: begin
                mul_req.start = 1'b1;
                n_state       = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (mul_valid) begin
                    if (r_phase == PH_W) begin
                        w_we = 1'b1;
                    end else begin
                        n_acc = r_acc - ACC_W'(mul_res);
                    end
                    n_k     = r_k + CNT_W'(1);
                    n_state = ST_LOOP;
                end
            end
            ST_DWAIT: begin
                if (div_valid) begin
                    n_state = ST_LOOP;
                    if (r_phase == PH_L) begin
                        l_we    = 1'b1;
                        n_i     = r_i + CNT_W'(1);
                        n_k     = '0;
                        n_first = 1'b1;
                    end else if (r_phase == PH_Z) begin
                        x_we    = 1'b1;
                        x_wdata = div_quot;
                        n_i     = r_i + CNT_W'(1);
                    end else begin
                        n_weight = div_quot;
                        n_equal  = r_flat;
                        n_perr   = 1'b0;
                        n_last   = (r_i + CNT_W'(1)) == i_cfg.n;
                        n_state  = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_LOOP;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_phase <= PH_W;
            r_count <= '0;
            r_err   <= 1'b0;
            r_flat  <= 1'b0;
            r_first <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_err   <= n_err;
            r_flat  <= n_flat;
            r_first <= n_first;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
        r_acc    <= n_acc;
        r_sum    <= n_sum;
        r_opb    <= n_opb;
        r_weight <= n_weight;
        r_equal  <= n_equal;
        r_perr   <= n_perr;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_a_mem[a_waddr] <= i_matrix_entry;
        end
        r_adata <= r_a_mem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_l_mem[l_waddr] <= l_wdata;
        end
        r_ldata <= r_l_mem[l_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_d[d_widx] <= d_wdata;
        end
        if (w_we) begin
            r_w[w_widx] <= w_wdata;
        end
        if (x_we) begin
            r_x[x_widx] <= x_wdata;
        end
    end

    assign o_stall          = r_state != ST_LOAD;
    assign o_valid          = r_state == ST_OUT;
    assign o_weight         = r_weight;
    assign o_equal_fallback = r_equal;
    assign o_pivot_error    = r_perr;
    assign o_last_weight    = r_last;

`ifndef SYNTH
    a_last_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_weight |=> ##1 r_state == ST_LOAD)
        else $error("load state not reached after last weight transfer");
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_pivot_error && o_equal_fallback))
        else $error("pivot error and equal fallback together");
    a_mul_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_valid |-> r_state == ST_MWAIT)
        else $error("multiplier result outside wait state");
    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_valid |-> r_state == ST_DWAIT)
        else $error("divider result outside wait state");
`endif

endmodule

// ===== design/min_variance_weight_solver_top.sv =====
// top level: configuration registers and the solver sequencer
//
// channel   direction  handshake                 payload
// input     in         i_valid / o_stall         i_matrix_entry, i_final_entry
// result    out        o_valid / i_stall         o_weight, o_equal_fallback,
//                                                o_pivot_error, o_last_weight
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// a matrix entry is taken whenever o_stall is low; the final entry starts the solve
// each multiply step runs in the shared multiplier, each division in the shared divider
// synchronous reset, no clearing pass; the stores hold data until written
// a stalled weight holds the sequencer until its transfer
`timescale 1ns / 1ps
module min_variance_weight_solver_top
    import mvws_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_word              i_matrix_entry,
    input  logic               i_final_entry,
    output logic               o_valid,
    input  logic               i_stall,
    output t_word              o_weight,
    output logic               o_equal_fallback,
    output logic               o_pivot_error,
    output logic               o_last_weight,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    logic [DIMR_W-1:0]  r_dimension;
    logic [LIMIT_W-1:0] r_limit;
    t_cfg               cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= DIM_RESET;
            r_limit     <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_DIMENSION) begin
                r_dimension <= i_cfg_data[DIMR_W-1:0];
            end else begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_comb begin
        cfg.limit = r_limit;
        if (r_dimension == '0) begin
            cfg.n = CNT_W'(1);
        end else if (int'(r_dimension) > MAX_DIM) begin
            cfg.n = CNT_W'(MAX_DIM);
        end else begin
            cfg.n = CNT_W'(r_dimension);
        end
    end

    assign o_cfg_ready = 1'b1;

    mvws_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (i_valid),
        .i_matrix_entry   (i_matrix_entry),
        .i_final_entry    (i_final_entry),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_weight         (o_weight),
        .o_equal_fallback (o_equal_fallback),
        .o_pivot_error    (o_pivot_error),
        .o_last_weight    (o_last_weight)
    );

endmodule

// ===== sim/mvws_weight_checker.sv =====
// channel monitor, weight predictor and scoreboard for the weight solver
`timescale 1ns / 1ps
module mvws_weight_checker
    import mvws_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  t_word              i_matrix_entry,
    input  logic               i_final_entry,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_word              i_weight,
    input  logic               i_equal_fallback,
    input  logic               i_pivot_error,
    input  logic               i_last_weight,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        t_word weight;
        bit    equal_fallback;
        bit    pivot_error;
        bit    last_weight;
    } t_weight_res;

    t_weight_res        weights_due[$];
    t_word              cov[DEPTH];
    t_word              piv[MAX_DIM];
    t_word              sol[MAX_DIM];
    int                 entry_cnt;
    logic [DIMR_W-1:0]  dim_reg;
    logic [LIMIT_W-1:0] limit_reg;

    assign o_pending = weights_due.size();

    function automatic t_word clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return t_word'(v);
    endfunction

    function automatic longint round_q24(input longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << 23)) >> 24;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_quot(input longint num, input longint den);
        longint unsigned mn, md, q;
        bit neg;
        neg = (num < 0) != (den < 0);
        mn  = (num < 0) ? longint'(-num) : num;
        md  = (den < 0) ? longint'(-den) : den;
        q   = (mn + md / 2) / md;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint mul24(input t_word a, input t_word b);
        return round_q24(longint'(a) * longint'(b));
    endfunction

    function automatic int dim_used();
        if (dim_reg == 0) return 1;
        if (dim_reg > MAX_DIM) return MAX_DIM;
        return int'(dim_reg);
    endfunction

    // ldlt factor, solve against ones, normalize by the sum (equal weights if near zero, zeros on a zero pivot)
    function automatic void solve_weights(input int n);
        t_word          low[MAX_DIM][MAX_DIM];
        bit             err, flat;
        longint         acc, wsum;
        longint unsigned mag;
        t_weight_res    r;
        err  = 0;
        flat = 0;
        wsum = 0;
        for (int a = 0; a < MAX_DIM; a++)
            for (int b = 0; b < MAX_DIM; b++) low[a][b] = '0;
        for (int j = 0; j < n; j++) begin
            acc = cov[j*n+j];
            for (int k = 0; k < j; k++)
                acc -= mul24(low[j][k], clip32(mul24(low[j][k], piv[k])));
            piv[j] = clip32(acc);
            if (piv[j] == 0) begin
                err = 1;
                break;
            end
            for (int i = j + 1; i < n; i++) begin
                acc = cov[i*n+j];
                for (int k = 0; k < j; k++)
                    acc -= mul24(low[i][k], clip32(mul24(low[j][k], piv[k])));
                low[i][j] = clip32(round_quot(longint'(clip32(acc)) * ONE_Q24, piv[j]));
            end
        end
        if (!err) begin
            for (int i = 0; i < n; i++) begin
                acc = ONE_Q16;
                for (int k = 0; k < i; k++) acc -= mul24(low[i][k], sol[k]);
                sol[i] = clip32(acc);
            end
            for (int i = 0; i < n; i++)
                sol[i] = clip32(round_quot(longint'(sol[i]) * ONE_Q16, piv[i]));
            for (int i = n - 1; i >= 0; i--) begin
                acc = sol[i];
                for (int k = i + 1; k < n; k++) acc -= mul24(low[k][i], sol[k]);
                sol[i] = clip32(acc);
            end
            for (int i = 0; i < n; i++) wsum += sol[i];
            mag  = (wsum < 0) ? longint'(-wsum) : wsum;
            flat = (mag << 8) < longint'(limit_reg);
        end
        for (int i = 0; i < n; i++) begin
            if (err) r.weight = '0;
            else if (flat) r.weight = t_word'((ONE_Q24 + n / 2) / n);
            else r.weight = clip32(round_quot(longint'(sol[i]) * ONE_Q24, wsum));
            r.equal_fallback = !err && flat;
            r.pivot_error    = err;
            r.last_weight    = (i + 1 == n);
            weights_due.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_weight_res e;
        int n;
        if (!i_rst_n) begin
            entry_cnt    = 0;
            dim_reg      = DIM_RESET;
            limit_reg    = LIMIT_RESET;
            o_fail_count = 0;
            weights_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (weights_due.size() == 0) begin
                    $error("unexpected weight transfer %0d", i_weight);
                    o_fail_count++;
                end else begin
                    e = weights_due.pop_front();
                    if (i_weight !== e.weight) begin
                        $error("weight exp %0d got %0d", e.weight, i_weight);
                        o_fail_count++;
                    end
                    if (i_equal_fallback !== e.equal_fallback) begin
                        $error("equal_fallback exp %0b got %0b", e.equal_fallback,
                               i_equal_fallback);
                        o_fail_count++;
                    end
                    if (i_pivot_error !== e.pivot_error) begin
                        $error("pivot_error exp %0b got %0b", e.pivot_error, i_pivot_error);
                        o_fail_count++;
                    end
                    if (i_last_weight !== e.last_weight) begin
                        $error("last_weight exp %0b got %0b", e.last_weight, i_last_weight);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                n = dim_used();
                if (entry_cnt < n * n) begin
                    cov[entry_cnt] = i_matrix_entry;
                    entry_cnt++;
                end
                if (i_final_entry) begin
                    entry_cnt = 0;
                    solve_weights(n);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DIMENSION) dim_reg = i_cfg_data[DIMR_W-1:0];
                else limit_reg = i_cfg_data;
            end
        end
    end

endmodule

// ===== sim/min_variance_weight_solver_top_tb.sv =====
// testbench top: clock, reset, covariance set stimulus and verdict
`timescale 1ns / 1ps
module min_variance_weight_solver_top_tb;
    import mvws_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    t_word              i_matrix_entry = '0;
    logic               i_final_entry = 0;
    logic               o_valid;
    logic               i_stall = 0;
    t_word              o_weight;
    logic               o_equal_fallback;
    logic               o_pivot_error;
    logic               o_last_weight;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_DIMENSION;
    logic [LIMIT_W-1:0] i_cfg_data = '0;

    int    fail_count;
    int    pending;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    cur_dim = 8;
    int    written_hw = 0;
    int    items_sent = 0;
    t_word cov_gen[MAX_DIM][MAX_DIM];

    always #5 i_clk = ~i_clk;

    min_variance_weight_solver_top i_dut (.*);

    mvws_weight_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_stall_in      (o_stall),
        .i_matrix_entry  (i_matrix_entry),
        .i_final_entry   (i_final_entry),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_weight        (o_weight),
        .i_equal_fallback(o_equal_fallback),
        .i_pivot_error   (o_pivot_error),
        .i_last_weight   (o_last_weight),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #50_000_000;
        $display("FAIL min_variance_weight_solver_top");
        $finish;
    end

    function automatic int eff_dim(input int d);
        return (d == 0) ? 1 : (d > MAX_DIM) ? MAX_DIM : d;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_entry(input t_word v, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid        <= 1;
        i_matrix_entry <= v;
        i_final_entry  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
        if (last) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int val);
        wait_drained();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[LIMIT_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
        if (idx == CFG_DIMENSION) cur_dim = val & 15;
    endtask

    // well-formed symmetric diagonally dominant matrix
    task automatic make_pd(input int n, input int diag_lo, input int diag_hi);
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= r; c++) begin
                if (r == c) cov_gen[r][c] = t_word'($urandom_range(diag_hi, diag_lo));
                else cov_gen[r][c] = t_word'(int'($urandom_range(16'h8000)) - 16'h4000);
                cov_gen[c][r] = cov_gen[r][c];
            end
    endtask

    task automatic make_noise(input int n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) cov_gen[r][c] = t_word'($urandom);
    endtask

    // count below n*n leaves old entries (raised to n*n until the store is filled once), above n*n adds ignored ones
    task automatic send_set(input int count);
        int n, lim;
        n   = eff_dim(cur_dim);
        lim = (count < n * n) ? count : n * n;
        if (lim < n * n && written_hw < n * n) count = n * n;
        for (int k = 0; k < count; k++)
            send_entry((k < n * n) ? cov_gen[k / n][k % n] : t_word'($urandom),
                       k == count - 1);
        if (count > written_hw) written_hw = (count < n * n) ? count : n * n;
    endtask

    task automatic random_set();
        int n, pick, cnt;
        n    = eff_dim(cur_dim);
        pick = $urandom_range(99);
        cnt  = n * n;
        if (pick < 70) begin
            make_pd(n, 32'h0002_0000, 32'h0040_0000);
        end else if (pick < 85) begin
            make_noise(n);
        end else begin
            make_pd(n, 32'h0002_0000, 32'h0040_0000);
            if ($urandom_range(1)) cnt = n * n + $urandom_range(3, 1);
            else cnt = (n * n > 1) ? $urandom_range(n * n - 1, 1) : 1;
        end
        send_set(cnt);
    endtask

    initial begin
        int start_items;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed
        make_pd(8, 32'h0002_0000, 32'h0040_0000);
        send_set(64);
        write_reg(CFG_DIMENSION, 0);
        cov_gen[0][0] = 32'sh7fffffff;
        send_set(1);
        cov_gen[0][0] = 32'sh80000000;
        send_set(1);
        write_reg(CFG_DIMENSION, 1);
        cov_gen[0][0] = '0;
        send_set(1);
        write_reg(CFG_DIMENSION, 15);
        make_pd(8, 32'h0002_0000, 32'h0040_0000);
        send_set(3);
        write_reg(CFG_DIMENSION, 2);
        write_reg(CFG_NEAR_ZERO, 65535);
        make_pd(2, 32'h03e8_0000, 32'h03e8_0000);
        send_set(4);
        write_reg(CFG_NEAR_ZERO, 0);
        write_reg(CFG_DIMENSION, 3);
        make_pd(3, 32'h0002_0000, 32'h0040_0000);
        send_set(12);

        // random phases
        for (int mode = 0; mode < 4; mode++) begin
            for (int sub = 0; sub < 3; sub++) begin
                write_reg(CFG_DIMENSION,
                          ($urandom_range(19) == 0) ? 8 : $urandom_range(4, 1));
                write_reg(CFG_NEAR_ZERO, ($urandom_range(3) == 0) ? 65535 :
                          ($urandom_range(3) == 0) ? 0 : $urandom_range(65535));
                send_idle_pct = (mode == 1) ? 56 : (mode == 3) ? 34 : 0;
                stall_pct     = (mode == 2) ? 56 : (mode == 3) ? 34 : 0;
                start_items   = items_sent;
                for (int s = 0; items_sent - start_items < 8; s++) begin
                    random_set();
                    if (mode == 2 && sub == 1 && s == 0) wait_drained();
                end
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS min_variance_weight_solver_top");
        end else begin
            $display("FAIL min_variance_weight_solver_top");
        end
        $finish;
    end

endmodule
